// ----- sv/frae_pkg.sv -----
`default_nettype none

package frae_pkg;

  localparam int REG_IDX_W = 2;

  // Operation codes carried in the func field.
  localparam logic [3:0] FN_IN   = 4'd0;
  localparam logic [3:0] FN_ADD  = 4'd1;
  localparam logic [3:0] FN_SUB  = 4'd2;
  localparam logic [3:0] FN_MUL  = 4'd3;
  localparam logic [3:0] FN_DIV  = 4'd4;
  localparam logic [3:0] FN_MOD  = 4'd5;
  localparam logic [3:0] FN_MOV  = 4'd6;
  localparam logic [3:0] FN_XCHG = 4'd7;
  localparam logic [3:0] FN_AND  = 4'd8;
  localparam logic [3:0] FN_OR   = 4'd9;
  localparam logic [3:0] FN_XOR  = 4'd10;
  localparam logic [3:0] FN_OUT  = 4'd11;

  typedef enum logic [1:0] {
    MDU_MUL,
    MDU_DIV,
    MDU_MOD
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_req_t;

  typedef struct packed {
    logic [3:0]           func;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [REG_IDX_W-1:0] src_reg;
    logic signed [31:0]   immediate;
  } in_item_t;

  typedef struct packed {
    logic               out_valid;
    logic signed [63:0] out_value;
    logic               div_by_zero;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/frae_in_if.sv -----
`default_nettype none

interface frae_in_if import frae_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/frae_out_if.sv -----
`default_nettype none

interface frae_out_if import frae_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/frae_ram.sv -----
`default_nettype none

module frae_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]              rdata_a_o,
  output logic [WIDTH-1:0]              rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ----- sv/frae_mdu.sv -----
`default_nettype none

// Iterative multiply / signed divide unit built around one shared adder.
module frae_mdu import frae_pkg::*; #(
  parameter int WW = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mdu_req_t      req_i,
  input  wire logic [WW-1:0] a_i,
  input  wire logic [WW-1:0] b_i,
  output logic               done_o,
  output logic [WW-1:0]      result_o
);

  localparam int CW = $clog2(WW);

  typedef enum logic [2:0] {
    M_IDLE,
    M_ABS_A,
    M_ABS_B,
    M_STEP,
    M_FIX
  } mstate_e;

  mstate_e       state_q;
  mdu_op_e       op_q;
  logic [WW-1:0] x_q;
  logic [WW-1:0] y_q;
  logic [WW-1:0] z_q;
  logic [CW-1:0] cnt_q;
  logic          na_q;
  logic          nb_q;
  logic          done_q;
  logic [WW-1:0] res_q;

  logic [WW-1:0] add_x;
  logic [WW-1:0] add_y;
  logic          add_sub;
  logic [WW:0]   sum;
  logic          neg_res;

  // Shared adder: x + y, or x - y with the carry out meaning "no borrow".
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      M_ABS_A: begin
        add_y   = z_q;
        add_sub = 1'b1;
      end
      M_ABS_B: begin
        add_y   = y_q;
        add_sub = 1'b1;
      end
      M_STEP: begin
        if (op_q == MDU_MUL) begin
          add_x = x_q;
          add_y = y_q;
        end else begin
          add_x   = {x_q[WW-2:0], z_q[WW-1]};
          add_y   = y_q;
          add_sub = 1'b1;
        end
      end
      M_FIX: begin
        add_y   = (op_q == MDU_DIV) ? z_q : x_q;
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y ^ {WW{add_sub}}} + (WW + 1)'(add_sub);

  always_comb begin
    case (op_q)
      MDU_DIV: neg_res = na_q ^ nb_q;
      MDU_MOD: neg_res = na_q;
      default: neg_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      op_q    <= MDU_MUL;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      cnt_q   <= '0;
      na_q    <= 1'b0;
      nb_q    <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            op_q  <= req_i.op;
            x_q   <= '0;
            cnt_q <= CW'(WW - 1);
            na_q  <= a_i[WW-1];
            nb_q  <= b_i[WW-1];
            if (req_i.op == MDU_MUL) begin
              y_q     <= a_i;
              z_q     <= b_i;
              state_q <= M_STEP;
            end else begin
              z_q     <= a_i;
              y_q     <= b_i;
              state_q <= M_ABS_A;
            end
          end
        end
        M_ABS_A: begin
          if (na_q) begin
            z_q <= sum[WW-1:0];
          end
          state_q <= M_ABS_B;
        end
        M_ABS_B: begin
          if (nb_q) begin
            y_q <= sum[WW-1:0];
          end
          state_q <= M_STEP;
        end
        M_STEP: begin
          if (op_q == MDU_MUL) begin
            if (z_q[0]) begin
              x_q <= sum[WW-1:0];
            end
            y_q <= {y_q[WW-2:0], 1'b0};
            z_q <= {1'b0, z_q[WW-1:1]};
          end else begin
            // Restoring division: keep the difference when no borrow occurred.
            if (sum[WW]) begin
              x_q <= sum[WW-1:0];
            end else begin
              x_q <= add_x;
            end
            z_q <= {z_q[WW-2:0], sum[WW]};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= M_FIX;
          end
        end
        M_FIX: begin
          if (neg_res) begin
            res_q <= sum[WW-1:0];
          end else begin
            res_q <= add_y;
          end
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: begin
          state_q <= M_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- sv/four_register_alu_executor.sv -----
// Register-file ALU instruction executor.
// The input channel in_i carries one decoded instruction per transfer: func,
// dest_reg, src_reg and a signed 32-bit immediate. Every instruction gives
// exactly one transfer on the output channel out_o: out_valid and out_value
// report the source register for an out instruction, div_by_zero flags a
// divide or modulo by zero, which leaves the destination unchanged.
// Instructions run one at a time. Loads, moves, add, sub and the logic
// operations pass from acceptance through a read and an execute state to
// the result register. Multiply, divide and modulo then run on from there
// one bit per cycle through a shared iterative multiply/divide unit that also
// forms the operand magnitudes and the final sign. Exchange needs an extra
// state for its second register write. in_i.ready is high only while no
// instruction is in flight; a new instruction may be taken while the previous
// result still waits in the output register.
// If the receiver stalls, the result holds in the output register and the
// block waits before its write-back until that register is free.
// Reset clears every register of the file to zero through per-entry valid
// bits and empties the output register; it takes effect at once.
`default_nettype none

module four_register_alu_executor import frae_pkg::*; #(
  parameter int NUM_REGS   = 4,
  parameter int WORD_WIDTH = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  frae_in_if.sink     in_i,
  frae_out_if.source  out_o
);

  localparam int AW = $clog2(NUM_REGS);
  localparam int WW = WORD_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WAIT,
    S_WB,
    S_XCHG
  } state_e;

  state_e                state_q;
  logic [3:0]            func_q;
  logic [REG_IDX_W-1:0]  dest_q;
  logic [REG_IDX_W-1:0]  src_q;
  logic signed [31:0]    imm_q;
  logic                  d_rng_q;
  logic                  s_rng_q;
  logic                  a_ok_q;
  logic                  b_ok_q;
  logic [WW-1:0]         a_q;
  logic [WW-1:0]         b_q;
  logic [WW-1:0]         res_q;
  logic                  wr_q;
  logic                  dz_q;
  logic                  ov_q;
  logic                  xchg_q;
  logic [NUM_REGS-1:0]   vld_q;
  logic                  out_vld_q;
  out_item_t             out_data_q;

  logic                  accept;
  logic                  d_rng_in;
  logic                  s_rng_in;
  logic [AW-1:0]         ra_a;
  logic [AW-1:0]         ra_b;
  logic [WW-1:0]         rdata_a;
  logic [WW-1:0]         rdata_b;
  logic                  slot_free;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WW-1:0]         ram_wdata;
  mdu_req_t              mdu_req;
  logic                  mdu_done;
  logic [WW-1:0]         mdu_result;

  logic signed [63:0]    imm64;
  logic signed [WW-1:0]  res_s;
  logic [WW-1:0]         ex_res;
  logic                  ex_wr;
  logic                  ex_dz;
  logic                  ex_ov;
  logic                  ex_xchg;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && (state_q == S_IDLE);
  assign d_rng_in   = int'(in_i.data.dest_reg) < NUM_REGS;
  assign s_rng_in   = int'(in_i.data.src_reg) < NUM_REGS;
  assign ra_a       = AW'(in_i.data.dest_reg);
  assign ra_b       = AW'(in_i.data.src_reg);
  assign slot_free  = !out_vld_q || out_o.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(dest_q);
    ram_wdata = res_q;
    if (state_q == S_WB) begin
      ram_we = slot_free && wr_q && d_rng_q;
    end else if (state_q == S_XCHG) begin
      ram_we    = s_rng_q;
      ram_waddr = AW'(src_q);
      ram_wdata = a_q;
    end
  end

  frae_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_REGS)
  ) u_regs (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (accept),
    .raddr_a_i (ra_a),
    .raddr_b_i (ra_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    mdu_req.start = 1'b0;
    mdu_req.op    = MDU_MOD;
    if (func_q == FN_MUL) begin
      mdu_req.op = MDU_MUL;
    end else if (func_q == FN_DIV) begin
      mdu_req.op = MDU_DIV;
    end
    if (state_q == S_EXEC) begin
      mdu_req.start = (func_q == FN_MUL) ||
                      (((func_q == FN_DIV) || (func_q == FN_MOD)) && (b_q != '0));
    end
  end

  frae_mdu #(
    .WW (WW)
  ) u_mdu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mdu_req),
    .a_i      (a_q),
    .b_i      (b_q),
    .done_o   (mdu_done),
    .result_o (mdu_result)
  );

  assign imm64 = 64'(imm_q);
  assign res_s = res_q;

  always_comb begin
    ex_res  = '0;
    ex_wr   = 1'b0;
    ex_dz   = 1'b0;
    ex_ov   = 1'b0;
    ex_xchg = 1'b0;
    case (func_q)
      FN_IN: begin
        ex_res = imm64[WW-1:0];
        ex_wr  = 1'b1;
      end
      FN_ADD: begin
        ex_res = a_q + b_q;
        ex_wr  = 1'b1;
      end
      FN_SUB: begin
        ex_res = a_q - b_q;
        ex_wr  = 1'b1;
      end
      FN_MUL: begin
        ex_wr = 1'b1;
      end
      FN_DIV, FN_MOD: begin
        ex_dz = (b_q == '0);
        ex_wr = (b_q != '0);
      end
      FN_MOV: begin
        ex_res = b_q;
        ex_wr  = 1'b1;
      end
      FN_XCHG: begin
        ex_res  = b_q;
        ex_wr   = 1'b1;
        ex_xchg = 1'b1;
      end
      FN_AND: begin
        ex_res = a_q & b_q;
        ex_wr  = 1'b1;
      end
      FN_OR: begin
        ex_res = a_q | b_q;
        ex_wr  = 1'b1;
      end
      FN_XOR: begin
        ex_res = a_q ^ b_q;
        ex_wr  = 1'b1;
      end
      FN_OUT: begin
        ex_res = b_q;
        ex_ov  = 1'b1;
      end
      default: begin
        ex_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      func_q     <= '0;
      dest_q     <= '0;
      src_q      <= '0;
      imm_q      <= '0;
      d_rng_q    <= 1'b0;
      s_rng_q    <= 1'b0;
      a_ok_q     <= 1'b0;
      b_ok_q     <= 1'b0;
      a_q        <= '0;
      b_q        <= '0;
      res_q      <= '0;
      wr_q       <= 1'b0;
      dz_q       <= 1'b0;
      ov_q       <= 1'b0;
      xchg_q     <= 1'b0;
      vld_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      // In the write-back state a freed output register is refilled below.
      if (out_vld_q && out_o.ready && (state_q != S_WB)) begin
        out_vld_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            func_q  <= in_i.data.func;
            dest_q  <= in_i.data.dest_reg;
            src_q   <= in_i.data.src_reg;
            imm_q   <= in_i.data.immediate;
            d_rng_q <= d_rng_in;
            s_rng_q <= s_rng_in;
            // A register never written since reset reads as zero.
            a_ok_q  <= d_rng_in && vld_q[ra_a];
            b_ok_q  <= s_rng_in && vld_q[ra_b];
            state_q <= S_READ;
          end
        end
        S_READ: begin
          a_q     <= a_ok_q ? rdata_a : '0;
          b_q     <= b_ok_q ? rdata_b : '0;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          res_q   <= ex_res;
          wr_q    <= ex_wr;
          dz_q    <= ex_dz;
          ov_q    <= ex_ov;
          xchg_q  <= ex_xchg;
          state_q <= mdu_req.start ? S_WAIT : S_WB;
        end
        S_WAIT: begin
          if (mdu_done) begin
            res_q   <= mdu_result;
            state_q <= S_WB;
          end
        end
        S_WB: begin
          if (slot_free) begin
            out_vld_q              <= 1'b1;
            out_data_q.out_valid   <= ov_q;
            out_data_q.out_value   <= ov_q ? 64'(res_s) : '0;
            out_data_q.div_by_zero <= dz_q;
            state_q                <= xchg_q ? S_XCHG : S_IDLE;
          end
        end
        S_XCHG: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;

endmodule

`default_nettype wire
